// ===== design/tape_pulse_audio_encoder_defines.svh =====
// Assertion macros used by the encoder back end.
// Each macro expects signals named clk and rst in the using module.
`ifndef TAPE_PULSE_AUDIO_ENCODER_DEFINES_SVH
`define TAPE_PULSE_AUDIO_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPAE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpae: check failed");

// Next-cycle implication, disabled during reset.
`define TPAE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpae: check failed");

`endif

// ===== design/tpae_pkg.sv =====
package tpae_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMD_DEPTH       = 2;

  localparam int LEN_W   = 17;
  localparam int CNT_W   = 16;
  localparam int DIVR_W  = 8;
  localparam int SUM_W   = LEN_W + 1;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEN_W-1:0] SYNC1_LEN = LEN_W'(1334);
  localparam logic [LEN_W-1:0] SYNC2_LEN = LEN_W'(1470);

  localparam logic [7:0] LEVEL_LOW  = 8'h40;
  localparam logic [7:0] LEVEL_HIGH = 8'hC0;
  localparam logic [7:0] LEVEL_IDLE = 8'h80;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DIVISOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_LENGTH       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LENGTH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LENGTH         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_COUNT_HEADER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PILOT_COUNT_DATA   = 3'd6;

  localparam logic [DIVR_W-1:0] RST_SAMPLE_DIVISOR     = 8'd160;
  localparam logic [1:0]        RST_CHANNEL_MODE       = 2'd0;
  localparam logic [LEN_W-1:0]  RST_PILOT_LENGTH       = LEN_W'(4336);
  localparam logic [LEN_W-1:0]  RST_ZERO_LENGTH        = LEN_W'(1710);
  localparam logic [LEN_W-1:0]  RST_ONE_LENGTH         = LEN_W'(3420);
  localparam logic [CNT_W-1:0]  RST_PILOT_COUNT_HEADER = CNT_W'(8063);
  localparam logic [CNT_W-1:0]  RST_PILOT_COUNT_DATA   = CNT_W'(3223);

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       sample_valid;
    logic [7:0] left_sample;
    logic [7:0] right_sample;
    logic       byte_accepted;
    logic       underrun;
    logic       busy_res;
  } res_item_t;

  typedef struct packed {
    logic       is_tick;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  typedef struct packed {
    logic [DIVR_W-1:0] sample_divisor;
    logic [1:0]        channel_mode;
    logic [LEN_W-1:0]  pilot_length;
    logic [LEN_W-1:0]  zero_length;
    logic [LEN_W-1:0]  one_length;
    logic [CNT_W-1:0]  pilot_count_header;
    logic [CNT_W-1:0]  pilot_count_data;
  } cfg_t;

endpackage

// ===== design/tpae_ram.sv =====
module tpae_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tpae_div.sv =====
module tpae_div import tpae_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [SUM_W-1:0]  quotient,
  output logic [DIVR_W-1:0] remainder
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [SUM_W-1:0]  dvd;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // restoring division, one quotient bit per cycle
  assign trial = {remainder, dvd[SUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        steps     <= STEP_W'(SUM_W);
        dvd       <= dividend;
        quotient  <= '0;
        remainder <= '0;
      end else if (busy) begin
        dvd      <= {dvd[SUM_W-2:0], 1'b0};
        quotient <= {quotient[SUM_W-2:0], fits};
        if (fits) begin
          remainder <= DIVR_W'(trial - {1'b0, divisor});
        end else begin
          remainder <= trial[DIVR_W-1:0];
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/tpae_front.sv =====
module tpae_front import tpae_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int FW = $clog2(CMD_DEPTH + 1);

  cmd_t          cmd_q [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;
  cmd_t          incoming;

  assign in_ready  = fill != FW'(CMD_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd       = cmd_q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // classify: ticks versus byte pushes; the first-byte mark carries no work
  assign incoming.is_tick   = in_data.op == OP_TICK;
  assign incoming.data_byte = in_data.data_byte;
  assign incoming.last_byte = in_data.last_byte;

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + FW'(push) - FW'(pop);
    end
  end

endmodule

// ===== design/tpae_back.sv =====
`include "tape_pulse_audio_encoder_defines.svh"

module tpae_back import tpae_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t out_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMD   = 7'b0000010,
    S_NEXT  = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_TAKE  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PILOT = 7'b0000010,
    PH_SYNC1 = 7'b0000100,
    PH_SYNC2 = 7'b0001000,
    PH_BITS  = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_END   = 7'b1000000
  } phase_t;

  state_t            state;
  phase_t            phase;
  cmd_t              cur;
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [CW-1:0]     count;
  logic [CNT_W-1:0]  pulse_counter;
  logic [7:0]        shift_byte;
  logic [3:0]        half_bit_count;
  logic              previous_bit;
  logic [CNT_W-1:0]  remaining_samples;
  logic [DIVR_W-1:0] remainder;
  logic              output_level;
  logic              block_ending;
  logic              res_sample_valid;
  logic [7:0]        res_left;
  logic [7:0]        res_right;
  logic              res_accepted;
  logic              res_underrun;
  logic              div_start;
  logic [LEN_W-1:0]  div_len;

  logic              q_we;
  logic [8:0]        q_rdata;
  logic              queue_full;
  logic [SUM_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic              div_done;
  logic [SUM_W-1:0]  div_quot;
  logic [DIVR_W-1:0] div_rem;
  logic [CNT_W-1:0]  pulse_samples;
  logic [7:0]        lvl_left;
  logic [7:0]        lvl_right;
  logic              out_load;

  assign cmd_ready  = state == S_IDLE;
  assign queue_full = count == CW'(QUEUE_DEPTH);
  assign q_we       = (state == S_CMD) && !cur.is_tick && !queue_full;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);

  assign lvl_left  = output_level ? LEVEL_LOW : LEVEL_HIGH;
  assign lvl_right = cfg.channel_mode[1] ? (output_level ? LEVEL_HIGH : LEVEL_LOW) : lvl_left;

  assign div_dividend  = {1'b0, div_len} + SUM_W'(remainder);
  assign div_divisor   = (cfg.sample_divisor == '0) ? DIVR_W'(1) : cfg.sample_divisor;
  // saturate the sample count to sixteen bits
  assign pulse_samples = (div_quot[SUM_W-1:CNT_W] != '0) ? '1 : div_quot[CNT_W-1:0];

  tpae_ram #(
    .WIDTH(9),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(tail),
    .wdata({cur.last_byte, cur.data_byte}),
    .raddr(head),
    .rdata(q_rdata)
  );

  tpae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      phase             <= PH_IDLE;
      head              <= '0;
      tail              <= '0;
      count             <= '0;
      pulse_counter     <= '0;
      shift_byte        <= '0;
      half_bit_count    <= '0;
      previous_bit      <= 1'b0;
      remaining_samples <= '0;
      remainder         <= '0;
      output_level      <= 1'b0;
      block_ending      <= 1'b0;
      div_start         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur              <= cmd;
            res_sample_valid <= cmd.is_tick;
            res_left         <= LEVEL_IDLE;
            res_right        <= LEVEL_IDLE;
            res_accepted     <= 1'b0;
            res_underrun     <= 1'b0;
            state            <= S_CMD;
          end
        end

        S_CMD: begin
          if (!cur.is_tick) begin
            // drop the byte when the queue is full
            if (!queue_full) begin
              tail         <= (tail == PW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
              count        <= count + 1'b1;
              res_accepted <= 1'b1;
            end
            state <= S_DONE;
          end else if (remaining_samples != '0) begin
            res_left          <= lvl_left;
            res_right         <= lvl_right;
            remaining_samples <= remaining_samples - 1'b1;
            if (remaining_samples == CNT_W'(1)) begin
              output_level <= ~output_level;
            end
            state <= S_DONE;
          end else begin
            state <= S_NEXT;
          end
        end

        S_NEXT: begin
          case (phase)
            PH_IDLE: begin
              state <= (count == '0) ? S_DONE : S_FETCH;
            end
            PH_PILOT: begin
              if (pulse_counter != '0) begin
                pulse_counter <= pulse_counter - 1'b1;
                div_len       <= cfg.pilot_length;
                div_start     <= 1'b1;
                state         <= S_DIV;
              end else begin
                phase <= PH_SYNC1;
              end
            end
            PH_SYNC1: begin
              div_len   <= SYNC1_LEN;
              div_start <= 1'b1;
              phase     <= PH_SYNC2;
              state     <= S_DIV;
            end
            PH_SYNC2: begin
              div_len   <= SYNC2_LEN;
              div_start <= 1'b1;
              phase     <= PH_BITS;
              state     <= S_DIV;
            end
            PH_BITS: begin
              if (half_bit_count == '0) begin
                if (block_ending) begin
                  block_ending <= 1'b0;
                  phase        <= PH_TRAIL;
                end else if (count == '0) begin
                  res_underrun <= 1'b1;
                  state        <= S_DONE;
                end else begin
                  state <= S_FETCH;
                end
              end else begin
                previous_bit   <= shift_byte[7];
                div_len        <= shift_byte[7] ? cfg.one_length : cfg.zero_length;
                div_start      <= 1'b1;
                half_bit_count <= half_bit_count + 1'b1;
                // advance to the next bit after its second pulse
                if (half_bit_count[0]) begin
                  shift_byte <= {shift_byte[6:0], 1'b0};
                end
                state <= S_DIV;
              end
            end
            PH_TRAIL: begin
              div_len   <= previous_bit ? cfg.one_length : cfg.zero_length;
              div_start <= 1'b1;
              phase     <= PH_END;
              state     <= S_DIV;
            end
            default: begin
              phase <= PH_IDLE;
            end
          endcase
        end

        S_FETCH: begin
          state <= S_TAKE;
        end

        S_TAKE: begin
          if (phase == PH_IDLE) begin
            pulse_counter  <= q_rdata[7] ? cfg.pilot_count_data : cfg.pilot_count_header;
            half_bit_count <= '0;
            block_ending   <= 1'b0;
            phase          <= PH_PILOT;
            state          <= S_NEXT;
          end else begin
            shift_byte     <= q_rdata[7:0];
            block_ending   <= q_rdata[8];
            head           <= (head == PW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count          <= count - 1'b1;
            previous_bit   <= q_rdata[7];
            div_len        <= q_rdata[7] ? cfg.one_length : cfg.zero_length;
            div_start      <= 1'b1;
            half_bit_count <= 4'd1;
            state          <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            remainder <= div_rem;
            if (pulse_samples == '0) begin
              output_level <= ~output_level;
              state        <= S_NEXT;
            end else begin
              res_left          <= lvl_left;
              res_right         <= lvl_right;
              remaining_samples <= pulse_samples - 1'b1;
              if (pulse_samples == CNT_W'(1)) begin
                output_level <= ~output_level;
              end
              state <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.sample_valid  <= res_sample_valid;
      out_data.left_sample   <= res_left;
      out_data.right_sample  <= res_right;
      out_data.byte_accepted <= res_accepted;
      out_data.underrun      <= res_underrun;
      out_data.busy_res      <= phase != PH_IDLE;
    end
  end

  `TPAE_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH))
  `TPAE_ASSERT_NEXT(a_done_hold, (state == S_DONE) && out_valid && !out_ready, state == S_DONE)
  `TPAE_ASSERT_IMPL(a_underrun_idle, out_valid && out_data.underrun, out_data.sample_valid && (out_data.left_sample == LEVEL_IDLE))
  `TPAE_ASSERT_NEXT(a_pop_one, (state == S_TAKE) && (phase == PH_BITS), count == $past(count) - 1'b1)

endmodule

// ===== design/tape_pulse_audio_encoder.sv =====
// Tape pulse audio encoder: plays tape block bytes as square-wave samples.
// Input channel (in_valid/in_ready/in_data) carries one beat per item: a
// byte push (op clear) or a sample tick (op set). Output channel
// (out_valid/out_ready/out_data) returns exactly one result beat per input
// beat, in order. Configuration registers are written through cfg_write,
// cfg_index and cfg_data, one register per cycle; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// A byte push, or a tick inside a running pulse, needs no division; a tick
// that must start a new pulse waits on the 18-step serial divider that
// turns a pulse length into a sample count. Pulses that round to zero
// samples chain within one tick, each taking a further division.
// A two-beat command queue takes new beats while the engine is busy, and a
// single output register holds a finished result while the receiver stalls;
// the engine waits on that register and the command queue fills behind it.
// Reset (rst, synchronous) empties the byte queue and command queue, clears
// the pulse state and loads the default register values. No memory clearing
// pass is needed: queue entries are only read after being written.
module tape_pulse_audio_encoder import tpae_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_divisor     <= RST_SAMPLE_DIVISOR;
      cfg.channel_mode       <= RST_CHANNEL_MODE;
      cfg.pilot_length       <= RST_PILOT_LENGTH;
      cfg.zero_length        <= RST_ZERO_LENGTH;
      cfg.one_length         <= RST_ONE_LENGTH;
      cfg.pilot_count_header <= RST_PILOT_COUNT_HEADER;
      cfg.pilot_count_data   <= RST_PILOT_COUNT_DATA;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_DIVISOR:     cfg.sample_divisor     <= cfg_data[DIVR_W-1:0];
        REG_CHANNEL_MODE:       cfg.channel_mode       <= cfg_data[1:0];
        REG_PILOT_LENGTH:       cfg.pilot_length       <= cfg_data[LEN_W-1:0];
        REG_ZERO_LENGTH:        cfg.zero_length        <= cfg_data[LEN_W-1:0];
        REG_ONE_LENGTH:         cfg.one_length         <= cfg_data[LEN_W-1:0];
        REG_PILOT_COUNT_HEADER: cfg.pilot_count_header <= cfg_data[CNT_W-1:0];
        REG_PILOT_COUNT_DATA:   cfg.pilot_count_data   <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify beats into the command queue
  tpae_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // back: byte queue, pulse sequencer, divider and output register
  tpae_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
